// ===== design/tpll_pkg.sv =====
// Package of the three-phase grid PLL lock block: state and index codes,
// configuration record, CORDIC angle table and shared widths. No dependencies.
`default_nettype none
package tpll_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int PHASE_WIDTH_DEF  = 16;
  localparam int COUNT_WIDTH_DEF  = 16;

  localparam int NORM_W     = 16;
  localparam int FREQ_W     = 24;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [2:0] {
    ST_STOP  = 3'd0,
    ST_START = 3'd1,
    ST_CONN  = 3'd2,
    ST_RUN   = 3'd3,
    ST_FAULT = 3'd4
  } lock_state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN   = 4'd0,
    CFG_INT_GAIN    = 4'd1,
    CFG_PHASE_GAIN  = 4'd2,
    CFG_LOCK_TOL    = 4'd3,
    CFG_START_WIN   = 4'd4,
    CFG_RUN_WIN     = 4'd5,
    CFG_START_LIMIT = 4'd6,
    CFG_RUN_LIMIT   = 4'd7
  } cfg_idx_t;

  typedef enum logic [3:0] {
    F_IDLE, F_PRE, F_ROT, F_HALVE, F_SQX, F_SQY, F_ROOT, F_MAG, F_DIVX, F_DIVY, F_DONE
  } front_state_t;

  typedef enum logic [2:0] {
    L_IDLE, L_MUL_I, L_ADD_I, L_MUL_P, L_ADD_P, L_MUL_F, L_COMMIT
  } loop_state_t;

  typedef struct packed {
    logic [15:0] prop_gain;
    logic [15:0] int_gain;
    logic [15:0] phase_gain;
    logic [19:0] lock_tol;
    logic [22:0] start_win;
    logic [22:0] run_win;
    logic [15:0] start_limit;
    logic [15:0] run_limit;
  } pll_cfg_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] xn;
    logic signed [NORM_W-1:0] yn;
  } front_res_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] xn;
    logic signed [NORM_W-1:0] yn;
    logic signed [FREQ_W-1:0] freq;
    lock_state_t              lock;
    lock_state_t              reported;
    logic                     fault;
  } loop_out_t;

  // atan(2^-i) in units of 2^32 per turn.
  function automatic logic [31:0] cordic_angle(input logic [3:0] i);
    logic [31:0] a;
    unique case (i)
      4'd0:  a = 32'h20000000;
      4'd1:  a = 32'h12E4051E;
      4'd2:  a = 32'h09FB385B;
      4'd3:  a = 32'h051111D4;
      4'd4:  a = 32'h028B0D43;
      4'd5:  a = 32'h0145D7E1;
      4'd6:  a = 32'h00A2F61E;
      4'd7:  a = 32'h00517C55;
      4'd8:  a = 32'h0028BE53;
      4'd9:  a = 32'h00145F2F;
      4'd10: a = 32'h000A2F98;
      4'd11: a = 32'h000517CC;
      4'd12: a = 32'h00028BE6;
      4'd13: a = 32'h000145F3;
      4'd14: a = 32'h0000A2FA;
      default: a = 32'h0000517D;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// ===== design/tpll_cfg.sv =====
// Configuration register bank of the grid PLL lock block.
// Depends on tpll_pkg for the register index codes and the record type.
`default_nettype none
module tpll_cfg import tpll_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output pll_cfg_t                   cfg
);

  pll_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain   <= 16'd256;
      cfg_r.int_gain    <= 16'd16;
      cfg_r.phase_gain  <= 16'd16;
      cfg_r.lock_tol    <= 20'd1024;
      cfg_r.start_win   <= 23'd524288;
      cfg_r.run_win     <= 23'd524288;
      cfg_r.start_limit <= 16'd1000;
      cfg_r.run_limit   <= 16'd1000;
    end else if (wr_en) begin
      unique case (cfg_idx_t'(wr_index))
        CFG_PROP_GAIN:   cfg_r.prop_gain   <= wr_data[15:0];
        CFG_INT_GAIN:    cfg_r.int_gain    <= wr_data[15:0];
        CFG_PHASE_GAIN:  cfg_r.phase_gain  <= wr_data[15:0];
        CFG_LOCK_TOL:    cfg_r.lock_tol    <= wr_data[19:0];
        CFG_START_WIN:   cfg_r.start_win   <= wr_data[22:0];
        CFG_RUN_WIN:     cfg_r.run_win     <= wr_data[22:0];
        CFG_START_LIMIT: cfg_r.start_limit <= wr_data[15:0];
        CFG_RUN_LIMIT:   cfg_r.run_limit   <= wr_data[15:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ===== design/tpll_front.sv =====
// Vector front end: Clarke transform, iterative CORDIC rotation, scaling,
// bit-serial square root and restoring division. Depends on tpll_pkg.
`default_nettype none
module tpll_front import tpll_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int PHASE_WIDTH  = PHASE_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic signed [SAMPLE_WIDTH-1:0] volt_r,
  input  wire logic signed [SAMPLE_WIDTH-1:0] volt_s,
  input  wire logic signed [SAMPLE_WIDTH-1:0] volt_t,
  input  wire logic        [PHASE_WIDTH-1:0]  phase,
  output logic                                done,
  output front_res_t                          res
);

  localparam int XW = (SAMPLE_WIDTH + 13 > 32) ? SAMPLE_WIDTH + 13 : 32;
  localparam int DW = SAMPLE_WIDTH + 2;

  front_state_t state_r, state_nxt;

  logic signed [XW-1:0] x_r, y_r;
  logic signed [33:0]   z_r;
  logic [4:0]           cnt_r;
  logic [59:0]          sq_r;
  logic [61:0]          n_r, root_r, bit_r;
  logic [46:0]          rem_r, ds_r;
  logic [16:0]          quo_r;
  logic signed [NORM_W-1:0] xn_r, yn_r;

  // Clarke pair scaled to integers: alpha' = (t-s)*443, beta' = (2r-s-t)*256.
  logic signed [DW-1:0] d_ts, d_b;
  logic signed [XW-1:0] x0, y0;
  logic [31:0]          g32, zu;

  always_comb begin
    d_ts = DW'(volt_t) - DW'(volt_s);
    d_b  = (DW'(volt_r) <<< 1) - DW'(volt_s) - DW'(volt_t);
    x0   = XW'(d_ts) * $signed(XW'(443));
    y0   = XW'(d_b) <<< 8;
    g32  = 32'(phase) << (32 - PHASE_WIDTH);
    zu   = 32'd0 - g32;
  end

  localparam logic signed [33:0] QUARTER = 34'sh040000000;
  localparam logic signed [33:0] HALF    = 34'sh080000000;
  localparam logic signed [XW-1:0] LIM   = XW'(64'sd1073741824);

  logic signed [XW-1:0] dx, dy;
  logic signed [33:0]   ang;
  logic                 need_halve;
  logic [29:0]          ax, ay;
  logic [61:0]          root_sum;
  logic                 root_ge, div_ge;
  logic [16:0]          q_next;
  logic [30:0]          mag;

  always_comb begin
    dx         = y_r >>> cnt_r[3:0];
    dy         = x_r >>> cnt_r[3:0];
    ang        = $signed({2'b00, cordic_angle(cnt_r[3:0])});
    need_halve = (x_r >= LIM) || (x_r <= -LIM) || (y_r >= LIM) || (y_r <= -LIM);
    ax         = x_r[XW-1] ? 30'(-x_r) : 30'(x_r);
    ay         = y_r[XW-1] ? 30'(-y_r) : 30'(y_r);
    root_sum   = root_r + bit_r;
    root_ge    = n_r >= root_sum;
    div_ge     = rem_r >= ds_r;
    q_next     = {quo_r[15:0], div_ge};
    mag        = root_r[30:0];
  end

  function automatic logic signed [NORM_W-1:0] sat_norm(input logic [16:0] q, input logic neg);
    logic signed [NORM_W-1:0] v;
    if (!neg) v = (q > 17'd32767) ? 16'sh7FFF : $signed(q[15:0]);
    else      v = (q > 17'd32768) ? 16'sh8000 : $signed(16'(-q));
    return v;
  endfunction

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE:  if (start) state_nxt = F_PRE;
      F_PRE:   state_nxt = F_ROT;
      F_ROT:   if (cnt_r == 5'd15) state_nxt = F_HALVE;
      F_HALVE: if (!need_halve) state_nxt = F_SQX;
      F_SQX:   state_nxt = F_SQY;
      F_SQY:   state_nxt = F_ROOT;
      F_ROOT:  if (bit_r[0]) state_nxt = F_MAG;
      F_MAG:   state_nxt = (mag == '0) ? F_DONE : F_DIVX;
      F_DIVX:  if (cnt_r == 5'd16) state_nxt = F_DIVY;
      F_DIVY:  if (cnt_r == 5'd16) state_nxt = F_DONE;
      F_DONE:  state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    done   = (state_r == F_DONE);
    res.xn = xn_r;
    res.yn = yn_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= F_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      F_IDLE: begin
        x_r <= x0;
        y_r <= y0;
        z_r <= 34'($signed(zu));
      end
      F_PRE: begin
        cnt_r <= '0;
        if (z_r > QUARTER) begin
          x_r <= -x_r; y_r <= -y_r; z_r <= z_r - HALF;
        end else if (z_r < -QUARTER) begin
          x_r <= -x_r; y_r <= -y_r; z_r <= z_r + HALF;
        end
      end
      F_ROT: begin
        cnt_r <= cnt_r + 5'd1;
        if (!z_r[33]) begin
          x_r <= x_r - dx; y_r <= y_r + dy; z_r <= z_r - ang;
        end else begin
          x_r <= x_r + dx; y_r <= y_r - dy; z_r <= z_r + ang;
        end
      end
      F_HALVE: begin
        // The shift rounds toward minus infinity, so negative values are nudged up first to truncate toward zero.
        if (need_halve) begin
          x_r <= (x_r + XW'(x_r[XW-1])) >>> 1;
          y_r <= (y_r + XW'(y_r[XW-1])) >>> 1;
        end
      end
      F_SQX: sq_r <= ax * ax;
      F_SQY: begin
        n_r    <= 62'(sq_r) + 62'(ay * ay);
        root_r <= '0;
        bit_r  <= 62'(1) << 60;
      end
      F_ROOT: begin
        if (root_ge) begin
          n_r    <= n_r - root_sum;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      F_MAG: begin
        cnt_r <= '0;
        quo_r <= '0;
        rem_r <= 47'(ax) << 15;
        ds_r  <= 47'(mag) << 16;
        if (mag == '0) begin
          xn_r <= '0;
          yn_r <= '0;
        end
      end
      F_DIVX, F_DIVY: begin
        if (cnt_r == 5'd16) begin
          cnt_r <= '0;
          quo_r <= '0;
          rem_r <= 47'(ay) << 15;
          ds_r  <= 47'(mag) << 16;
          if (state_r == F_DIVX) xn_r <= sat_norm(q_next, x_r[XW-1]);
          else                   yn_r <= sat_norm(q_next, y_r[XW-1]);
        end else begin
          cnt_r <= cnt_r + 5'd1;
          quo_r <= q_next;
          ds_r  <= ds_r >> 1;
          if (div_ge) rem_r <= rem_r - ds_r;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/tpll_loop.sv =====
// PI loop filter, phase integrator and lock supervisor of the grid PLL.
// One shared multiplier serves all gain products. Depends on tpll_pkg.
`default_nettype none
module tpll_loop import tpll_pkg::*; #(
  parameter int PHASE_WIDTH = PHASE_WIDTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire front_res_t             front,
  input  wire logic                   running,
  input  wire pll_cfg_t               cfg,
  input  wire logic                   commit_ok,
  output logic                        done,
  output logic [PHASE_WIDTH-1:0]      phase,
  output loop_out_t                   result
);

  localparam int LW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam logic signed [43:0] FMAX = 44'sd8388607;
  localparam logic signed [43:0] FMIN = -44'sd8388608;

  loop_state_t state_r, state_nxt;

  logic signed [FREQ_W-1:0]   int_r, int_new_r, freq_new_r;
  logic [PHASE_WIDTH-1:0]     ph_r;
  lock_state_t                ls_r, rep_r;
  logic                       fault_r;
  logic [COUNT_WIDTH-1:0]     smc_r, rmc_r;
  logic signed [NORM_W-1:0]   xn_r, yn_r;
  logic                       run_r;
  logic signed [41:0]         prod_r;

  function automatic logic signed [FREQ_W-1:0] sat_freq(input logic signed [43:0] v);
    logic signed [FREQ_W-1:0] r;
    if (v > FMAX)      r = FMAX[FREQ_W-1:0];
    else if (v < FMIN) r = FMIN[FREQ_W-1:0];
    else               r = v[FREQ_W-1:0];
    return r;
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] cnt_inc(input logic [COUNT_WIDTH-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic logic outside(input logic signed [FREQ_W-1:0] f, input logic [22:0] w);
    logic signed [FREQ_W:0] ws;
    ws = $signed({2'b00, w});
    return ((FREQ_W+1)'(f) > ws) || ((FREQ_W+1)'(f) < -ws);
  endfunction

  // Shared multiplier operands.
  logic signed [24:0] mul_a;
  logic signed [16:0] mul_b;

  always_comb begin
    mul_a = 25'(yn_r);
    mul_b = $signed({1'b0, cfg.int_gain});
    unique case (state_r)
      L_MUL_P: mul_b = $signed({1'b0, cfg.prop_gain});
      L_MUL_F: begin
        mul_a = 25'(freq_new_r);
        mul_b = $signed({1'b0, cfg.phase_gain});
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      L_IDLE:   if (start) state_nxt = L_MUL_I;
      L_MUL_I:  state_nxt = L_ADD_I;
      L_ADD_I:  state_nxt = L_MUL_P;
      L_MUL_P:  state_nxt = L_ADD_P;
      L_ADD_P:  state_nxt = L_MUL_F;
      L_MUL_F:  state_nxt = L_COMMIT;
      L_COMMIT: if (commit_ok) state_nxt = L_IDLE;
      default:  state_nxt = L_IDLE;
    endcase
  end

  // Lock supervisor and committed loop state.
  logic signed [FREQ_W:0]   step;
  logic                     step_ok;
  logic [PHASE_WIDTH-1:0]   ph_step;
  lock_state_t              ls_n, rep_n;
  logic                     fault_n;
  logic [COUNT_WIDTH-1:0]   smc_n, rmc_n;
  logic signed [FREQ_W-1:0] int_c, freq_c;
  logic [PHASE_WIDTH-1:0]   ph_c;

  always_comb begin
    step    = (FREQ_W+1)'(int_new_r) - (FREQ_W+1)'(int_r);
    step_ok = (step < $signed({5'b0, cfg.lock_tol})) && (step > -$signed({5'b0, cfg.lock_tol}));
    ph_step = PHASE_WIDTH'(prod_r >>> (36 - PHASE_WIDTH));
    ls_n    = ls_r;
    rep_n   = rep_r;
    fault_n = fault_r;
    smc_n   = smc_r;
    rmc_n   = rmc_r;
    int_c   = int_new_r;
    freq_c  = freq_new_r;
    ph_c    = ph_r + ph_step;
    unique case (ls_r)
      ST_FAULT: ls_n = ST_STOP;
      ST_START: begin
        if (outside(freq_new_r, cfg.start_win)) begin
          if (step_ok) begin
            ls_n = ST_CONN; rep_n = ST_CONN; fault_n = 1'b0; smc_n = '0;
          end else begin
            ls_n = ST_START; rep_n = ST_START; fault_n = 1'b1;
          end
        end else begin
          smc_n = cnt_inc(smc_r);
        end
        if (LW'(smc_n) >= LW'(cfg.start_limit)) begin
          smc_n = '0; ls_n = ST_START; rep_n = ST_START;
        end
      end
      ST_CONN, ST_RUN: begin
        if (outside(freq_new_r, cfg.run_win)) begin
          if (!step_ok) begin
            ls_n = ST_FAULT; rep_n = ST_FAULT; fault_n = 1'b1;
          end else begin
            rep_n = ls_r;
          end
        end else begin
          rmc_n = cnt_inc(rmc_r);
        end
        if (LW'(rmc_n) >= LW'(cfg.run_limit)) begin
          ls_n = ST_FAULT; rep_n = ST_FAULT; rmc_n = '0; fault_n = 1'b1;
        end
        if (ls_r == ST_CONN && run_r) begin
          ls_n = ST_RUN; rep_n = ST_RUN; rmc_n = '0;
        end else if (ls_r == ST_RUN && !run_r) begin
          ls_n = ST_STOP; rep_n = ST_STOP;
        end
      end
      default: begin
        int_c  = '0;
        freq_c = '0;
        ph_c   = '0;
        ls_n   = ST_START;
      end
    endcase
  end

  always_comb begin
    done              = (state_r == L_COMMIT) && commit_ok;
    phase             = ph_r;
    result.xn         = xn_r;
    result.yn         = yn_r;
    result.freq       = freq_c;
    result.lock       = ls_n;
    result.reported   = rep_n;
    result.fault      = fault_n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      int_r   <= '0;
      ph_r    <= '0;
      ls_r    <= ST_STOP;
      rep_r   <= ST_STOP;
      fault_r <= 1'b0;
      smc_r   <= '0;
      rmc_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (done) begin
        int_r   <= int_c;
        ph_r    <= ph_c;
        ls_r    <= ls_n;
        rep_r   <= rep_n;
        fault_r <= fault_n;
        smc_r   <= smc_n;
        rmc_r   <= rmc_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == L_IDLE && start) begin
      xn_r  <= front.xn;
      yn_r  <= front.yn;
      run_r <= running;
    end
    // The phase product is held while the commit waits for the output register.
    if (state_r != L_COMMIT)
      prod_r <= mul_a * mul_b;
    if (state_r == L_ADD_I)
      int_new_r <= sat_freq(44'(int_r) + 44'(prod_r >>> 11));
    if (state_r == L_ADD_P)
      freq_new_r <= sat_freq(44'(int_new_r) + 44'(prod_r >>> 3));
  end

endmodule
`default_nettype wire

// ===== design/three_phase_grid_pll_lock.sv =====
// Three-phase synchronous-reference-frame PLL with lock supervision.
// Depends on tpll_pkg, tpll_cfg, tpll_front and tpll_loop.
//
// Each input beat carries one sample of the three phase voltages and the
// converter run flag; exactly one result beat follows, carrying the phase
// held before the update, the normalised rotated components, the new
// frequency, the lock and reported states and the sync fault bit. The block
// takes one sample at a time and holds in_stall high until its result has
// been formed. The front end runs 16 CORDIC iterations, a scaling check
// (with halving steps where needed, which the default sample width never
// needs), a 31-step bit-serial square root and two 17-step restoring
// divisions, all on one shared datapath; both divisions are skipped when
// the rotated vector has zero length. The loop filter then forms its
// integral, proportional and phase products on a single shared multiplier
// and commits, waiting while a stalled output beat holds the output register.
// A finished result waits in the output register while the next sample is
// accepted.
// Configuration writes are always taken (cfg_ready is tied high) and are
// to be issued only while no sample is in flight.
`default_nettype none
module three_phase_grid_pll_lock import tpll_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int PHASE_WIDTH  = PHASE_WIDTH_DEF,
  parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic signed [SAMPLE_WIDTH-1:0] in_voltage_r,
  input  wire logic signed [SAMPLE_WIDTH-1:0] in_voltage_s,
  input  wire logic signed [SAMPLE_WIDTH-1:0] in_voltage_t,
  input  wire logic                           in_converter_running,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [PHASE_WIDTH-1:0]              out_phase_estimate,
  output logic signed [NORM_W-1:0]            out_direct_component,
  output logic signed [NORM_W-1:0]            out_quadrature_component,
  output logic signed [FREQ_W-1:0]            out_frequency_estimate,
  output logic [2:0]                          out_lock_state,
  output logic [2:0]                          out_reported_state,
  output logic                                out_sync_fault,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]           cfg_index,
  input  wire logic [CFG_DATA_W-1:0]          cfg_wdata
);

  pll_cfg_t               cfg;
  front_res_t             front_res;
  loop_out_t              loop_res;
  logic                   front_done, loop_done, accept, commit_ok;
  logic [PHASE_WIDTH-1:0] phase_now;

  logic                   busy_r, out_valid_r, running_r;
  logic [PHASE_WIDTH-1:0] old_phase_r;
  loop_out_t              out_r;
  logic [PHASE_WIDTH-1:0] out_phase_r;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !busy_r;
  assign in_stall  = busy_r;
  // The loop commits only when the output register is free or being emptied.
  assign commit_ok = !out_valid_r || !out_stall;

  tpll_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .cfg      (cfg)
  );

  tpll_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .PHASE_WIDTH  (PHASE_WIDTH)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (accept),
    .volt_r (in_voltage_r),
    .volt_s (in_voltage_s),
    .volt_t (in_voltage_t),
    .phase  (phase_now),
    .done   (front_done),
    .res    (front_res)
  );

  tpll_loop #(
    .PHASE_WIDTH (PHASE_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_loop (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (front_done),
    .front     (front_res),
    .running   (running_r),
    .cfg       (cfg),
    .commit_ok (commit_ok),
    .done      (loop_done),
    .phase     (phase_now),
    .result    (loop_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept)         busy_r <= 1'b1;
      else if (loop_done) busy_r <= 1'b0;
      if (loop_done)                     out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
  end

  // The phase reported with a result is the one in force when its sample arrived.
  always_ff @(posedge clk) begin
    if (accept) begin
      old_phase_r <= phase_now;
      running_r   <= in_converter_running;
    end
    if (loop_done) begin
      out_r       <= loop_res;
      out_phase_r <= old_phase_r;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_phase_estimate       = out_phase_r;
  assign out_direct_component     = out_r.xn;
  assign out_quadrature_component = out_r.yn;
  assign out_frequency_estimate   = out_r.freq;
  assign out_lock_state           = out_r.lock;
  assign out_reported_state       = out_r.reported;
  assign out_sync_fault           = out_r.fault;

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the three-phase grid PLL lock block.
// Depends on tpll_pkg and on the RTL of three_phase_grid_pll_lock only.
// A scoreboard class predicts every result beat and checks it as it leaves the block.
`default_nettype none
module testbench;
  import tpll_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3000000;
  localparam logic [CFG_IDX_W-1:0] CFG_BAD_IDX = 4'd12;
  localparam int RAND_PHASE_ITEMS = 250;
  localparam int LONG_HOLD_CYCLES = 600;
  localparam int DRAIN_CYCLES = 200;

  typedef struct {
    logic signed [15:0] vr;
    logic signed [15:0] vs;
    logic signed [15:0] vt;
    bit                 running;
  } grid_sample_t;

  typedef struct {
    logic [15:0]        phase;
    logic signed [15:0] direct;
    logic signed [15:0] quad;
    logic signed [23:0] freq;
    lock_state_t        lock;
    lock_state_t        reported;
    bit                 fault;
  } pll_result_t;

  // Tracks the loop state of the block and holds the results it still owes.
  class pll_scoreboard;
    longint kp, ki, kf, tol, win_start, win_run, lim_start, lim_run;
    longint integ, freq;
    logic [15:0] phase;
    lock_state_t lock, reported;
    bit fault;
    longint miss_start, miss_run;
    pll_result_t owed[$];
    int errors;
    longint atan_tab[16];

    function void init();
      kp = 256; ki = 16; kf = 16; tol = 1024;
      win_start = 524288; win_run = 524288; lim_start = 1000; lim_run = 1000;
      integ = 0; freq = 0; phase = '0;
      lock = ST_STOP; reported = ST_STOP; fault = 0;
      miss_start = 0; miss_run = 0;
      errors = 0;
      atan_tab = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
                   64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
                   64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
                   64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D};
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
      case (cfg_idx_t'(idx))
        CFG_PROP_GAIN:   kp = longint'(d[15:0]);
        CFG_INT_GAIN:    ki = longint'(d[15:0]);
        CFG_PHASE_GAIN:  kf = longint'(d[15:0]);
        CFG_LOCK_TOL:    tol = longint'(d[19:0]);
        CFG_START_WIN:   win_start = longint'(d[22:0]);
        CFG_RUN_WIN:     win_run = longint'(d[22:0]);
        CFG_START_LIMIT: lim_start = longint'(d[15:0]);
        CFG_RUN_LIMIT:   lim_run = longint'(d[15:0]);
        default: ;
      endcase
    endfunction

    function longint sat(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n = n - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function longint bump(longint c);
      return c < 65535 ? c + 1 : 65535;
    endfunction

    // An accepted input beat: advance the loop and store the result it causes.
    function void note(grid_sample_t smp);
      longint x, y, z, dx, dy, xn, yn, old_int, stp;
      longint unsigned mag;
      logic [31:0] ang;
      bit step_ok, out_w;
      lock_state_t keep;
      pll_result_t res;
      res.phase = phase;
      x = (longint'(smp.vt) - longint'(smp.vs)) * 443;
      y = (2 * longint'(smp.vr) - longint'(smp.vs) - longint'(smp.vt)) * 256;
      ang = 32'd0 - {phase, 16'd0};
      z = longint'($signed(ang));
      // Bring the angle into the CORDIC range with a half-turn flip.
      if (z > 64'sh40000000) begin
        x = -x; y = -y; z = z - 64'sh80000000;
      end else if (z < -64'sh40000000) begin
        x = -x; y = -y; z = z + 64'sh80000000;
      end
      for (int i = 0; i < 16; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx; y = y + dy; z = z - atan_tab[i];
        end else begin
          x = x + dx; y = y - dy; z = z + atan_tab[i];
        end
      end
      while (x >= 64'sh40000000 || x <= -64'sh40000000 ||
             y >= 64'sh40000000 || y <= -64'sh40000000) begin
        x = x / 2; y = y / 2;
      end
      mag = int_sqrt(longint'(x * x + y * y));
      xn = 0; yn = 0;
      if (mag != 0) begin
        xn = sat(x * 32768 / longint'(mag), -32768, 32767);
        yn = sat(y * 32768 / longint'(mag), -32768, 32767);
      end

      old_int = integ;
      integ = sat(old_int + ((yn * ki) >>> 11), -8388608, 8388607);
      freq = sat(integ + ((yn * kp) >>> 3), -8388608, 8388607);
      phase = phase + 16'((freq * kf) >>> 20);
      stp = integ - old_int;
      step_ok = (stp < tol) && (stp > -tol);

      case (lock)
        ST_FAULT: lock = ST_STOP;
        ST_START: begin
          if (freq > win_start || freq < -win_start) begin
            if (step_ok) begin
              reported = ST_CONN; lock = ST_CONN; fault = 0; miss_start = 0;
            end else begin
              fault = 1; reported = ST_START; lock = ST_START;
            end
          end else begin
            miss_start = bump(miss_start);
          end
          if (miss_start >= lim_start) begin
            miss_start = 0; reported = ST_START; lock = ST_START;
          end
        end
        ST_CONN, ST_RUN: begin
          keep = lock;
          out_w = freq > win_run || freq < -win_run;
          if (out_w) begin
            if (step_ok) begin
              reported = keep; lock = keep;
            end else begin
              reported = ST_FAULT; lock = ST_FAULT; fault = 1;
            end
          end else begin
            miss_run = bump(miss_run);
          end
          if (miss_run >= lim_run) begin
            reported = ST_FAULT; lock = ST_FAULT; miss_run = 0; fault = 1;
          end
          if (keep == ST_CONN && smp.running) begin
            reported = ST_RUN; lock = ST_RUN; miss_run = 0;
          end else if (keep == ST_RUN && !smp.running) begin
            reported = ST_STOP; lock = ST_STOP;
          end
        end
        default: begin
          // Stop clears the loop after its update and arms the start search.
          freq = 0; integ = 0; phase = '0; lock = ST_START;
        end
      endcase

      res.direct = 16'(xn);
      res.quad = 16'(yn);
      res.freq = 24'(freq);
      res.lock = lock;
      res.reported = reported;
      res.fault = fault;
      owed.push_back(res);
    endfunction

    function void field(string name, longint want, longint got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    // A result beat leaving the block is compared with the oldest owed result.
    function void check(pll_result_t got);
      pll_result_t want;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing owed, actual phase %0d", $time, got.phase);
        return;
      end
      want = owed.pop_front();
      field("phase_estimate", want.phase, got.phase);
      field("direct_component", want.direct, got.direct);
      field("quadrature_component", want.quad, got.quad);
      field("frequency_estimate", want.freq, got.freq);
      field("lock_state", want.lock, got.lock);
      field("reported_state", want.reported, got.reported);
      field("sync_fault", want.fault, got.fault);
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_voltage_r = '0;
  logic signed [15:0] in_voltage_s = '0;
  logic signed [15:0] in_voltage_t = '0;
  logic in_converter_running = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] out_phase_estimate;
  logic signed [15:0] out_direct_component;
  logic signed [15:0] out_quadrature_component;
  logic signed [23:0] out_frequency_estimate;
  logic [2:0] out_lock_state;
  logic [2:0] out_reported_state;
  logic out_sync_fault;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  pll_scoreboard pll_sb;
  // While quiet is set neither side idles; long_hold_req asks the receiver
  // for one long stall stretch, which it counts out in its own process.
  bit quiet = 1'b0;
  bit long_hold_req = 1'b0;
  int unsigned cycle_count = 0;

  // Waveform generator state for the well-formed three-phase sequences.
  real grid_ang, grid_step, grid_amp;
  int seg_left = 0;
  bit run_level = 1'b0;

  three_phase_grid_pll_lock dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_voltage_r(in_voltage_r), .in_voltage_s(in_voltage_s),
    .in_voltage_t(in_voltage_t), .in_converter_running(in_converter_running),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_phase_estimate(out_phase_estimate),
    .out_direct_component(out_direct_component),
    .out_quadrature_component(out_quadrature_component),
    .out_frequency_estimate(out_frequency_estimate),
    .out_lock_state(out_lock_state), .out_reported_state(out_reported_state),
    .out_sync_fault(out_sync_fault),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // The run is abandoned if it has not finished well beyond the slowest
  // correct run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, each drawn with a chance of 13 in a hundred, plus one long
  // hold stretch on request so that the block fills and stalls its input.
  int hold_left = 0;
  always @(posedge clk) begin
    if (long_hold_req) begin
      hold_left = LONG_HOLD_CYCLES;
      long_hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 13);
    end
  end

  // Monitor: a result beat is taken at an edge with out_valid high and
  // out_stall low, both seen as they stood before the edge.
  always @(posedge clk) begin
    pll_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.phase = out_phase_estimate;
      got.direct = out_direct_component;
      got.quad = out_quadrature_component;
      got.freq = out_frequency_estimate;
      got.lock = lock_state_t'(out_lock_state);
      got.reported = lock_state_t'(out_reported_state);
      got.fault = out_sync_fault;
      pll_sb.check(got);
    end
  end

  // Offers one sample beat and waits for it to be taken. An idle gap, when
  // one is drawn, lowers valid first so that valid is never lowered and
  // raised within the same step.
  task automatic send_sample(grid_sample_t smp);
    int gap;
    gap = (!quiet && $urandom_range(99) < 13) ? $urandom_range(1, 8) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_voltage_r <= smp.vr;
    in_voltage_s <= smp.vs;
    in_voltage_t <= smp.vt;
    in_converter_running <= smp.running;
    do @(posedge clk); while (in_stall);
    pll_sb.note(smp);
  endtask

  // Drops valid after the last beat of a phase and waits until every owed
  // result has come out, then a little longer, so the block is idle.
  task automatic drain();
    in_valid <= 1'b0;
    while (pll_sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Valid is lowered after each write before the next one, so valid is never lowered and
  // raised again within the same step.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pll_sb.set_reg(idx, d);
    @(posedge clk);
  endtask

  task automatic write_all(logic [31:0] kp, logic [31:0] ki, logic [31:0] kf,
                           logic [31:0] tol, logic [31:0] ws, logic [31:0] wr,
                           logic [31:0] ls, logic [31:0] lr);
    write_reg(CFG_PROP_GAIN, kp);
    write_reg(CFG_INT_GAIN, ki);
    write_reg(CFG_PHASE_GAIN, kf);
    write_reg(CFG_LOCK_TOL, tol);
    write_reg(CFG_START_WIN, ws);
    write_reg(CFG_RUN_WIN, wr);
    write_reg(CFG_START_LIMIT, ls);
    write_reg(CFG_RUN_LIMIT, lr);
  endtask

  function automatic logic signed [15:0] to_q15(real v);
    if (v > 32767.0) return 16'sd32767;
    if (v < -32768.0) return -16'sd32768;
    return 16'($rtoi(v));
  endfunction

  // Mostly balanced three-phase waveforms in segments of random amplitude,
  // frequency and run flag; the rest is raw noise on all three phases.
  function automatic grid_sample_t next_sample();
    grid_sample_t smp;
    if ($urandom_range(99) < 20) begin
      smp.vr = 16'($urandom);
      smp.vs = 16'($urandom);
      smp.vt = 16'($urandom);
      smp.running = $urandom_range(1);
      return smp;
    end
    if (seg_left == 0) begin
      seg_left = $urandom_range(20, 120);
      grid_amp = real'($urandom_range(0, 36000));
      grid_step = (real'($urandom_range(0, 2000)) - 1000.0) * 0.0005;
      grid_ang = real'($urandom_range(0, 6283)) * 0.001;
      run_level = $urandom_range(3) != 0;
    end
    seg_left--;
    grid_ang = grid_ang + grid_step;
    if ($urandom_range(99) < 3) run_level = !run_level;
    smp.vr = to_q15(grid_amp * $cos(grid_ang));
    smp.vs = to_q15(grid_amp * $cos(grid_ang - 2.0943951));
    smp.vt = to_q15(grid_amp * $cos(grid_ang + 2.0943951));
    smp.running = run_level;
    return smp;
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) send_sample(next_sample());
    drain();
  endtask

  function automatic grid_sample_t mk(logic signed [15:0] r, logic signed [15:0] s,
                                      logic signed [15:0] t, bit run);
    grid_sample_t smp;
    smp.vr = r; smp.vs = s; smp.vt = t; smp.running = run;
    return smp;
  endfunction

  initial begin
    grid_sample_t directed[$];
    pll_sb = new();
    pll_sb.init();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: the zero vector, equal phases (also a zero vector), the
    // field extremes, both run flags and a short clean waveform.
    directed.push_back(mk(16'sd0, 16'sd0, 16'sd0, 1'b0));
    directed.push_back(mk(16'sd0, 16'sd0, 16'sd0, 1'b1));
    directed.push_back(mk(16'sd32767, 16'sd32767, 16'sd32767, 1'b0));
    directed.push_back(mk(-16'sd32768, -16'sd32768, -16'sd32768, 1'b1));
    directed.push_back(mk(16'sd32767, -16'sd32768, -16'sd32768, 1'b1));
    directed.push_back(mk(-16'sd32768, 16'sd32767, 16'sd32767, 1'b0));
    directed.push_back(mk(16'sd0, -16'sd32768, 16'sd32767, 1'b1));
    directed.push_back(mk(16'sd0, 16'sd32767, -16'sd32768, 1'b1));
    directed.push_back(mk(16'sd1, 16'sd0, -16'sd1, 1'b0));
    directed.push_back(mk(-16'sd1, -16'sd1, 16'sd0, 1'b1));
    for (int i = 0; i < 12; i++)
      directed.push_back(mk(to_q15(30000.0 * $cos(0.3 * i)),
                            to_q15(30000.0 * $cos(0.3 * i - 2.0943951)),
                            to_q15(30000.0 * $cos(0.3 * i + 2.0943951)), i > 5));
    foreach (directed[i]) send_sample(directed[i]);
    drain();

    // Reset settings, with a stretch of no idling on either side.
    quiet = 1'b1;
    random_phase(RAND_PHASE_ITEMS);
    quiet = 1'b0;

    // Largest gains, widest tolerance, zero windows and longest limits.
    write_all(32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFFF, 32'd0, 32'd0,
              32'hFFFF, 32'hFFFF);
    // The receiver holds off while the sender keeps offering beats.
    long_hold_req = 1'b1;
    random_phase(RAND_PHASE_ITEMS);

    // Zero gains, zero tolerance, widest windows, limits of one.
    write_all(32'd0, 32'd0, 32'd0, 32'd0, 32'h7FFFFF, 32'h7FFFFF, 32'd1, 32'd1);
    random_phase(RAND_PHASE_ITEMS / 2);

    // Zero count limits and a write to an unused index, which is ignored.
    write_all(32'd512, 32'd200, 32'd300, 32'd4000, 32'd20000, 32'd20000,
              32'd0, 32'd0);
    write_reg(CFG_BAD_IDX, 32'hFFFFFFFF);
    random_phase(RAND_PHASE_ITEMS / 2);

    // Random settings, with small windows and limits so the lock machine moves.
    for (int p = 0; p < 3; p++) begin
      write_all($urandom_range(0, 65535), $urandom_range(0, 4000),
                $urandom_range(0, 65535), $urandom_range(0, 1048575),
                $urandom_range(0, 300000), $urandom_range(0, 300000),
                $urandom_range(0, 40), $urandom_range(0, 40));
      // Part way through, the sender waits until every owed result has come.
      for (int i = 0; i < RAND_PHASE_ITEMS; i++) begin
        if (i == RAND_PHASE_ITEMS / 2) begin
          in_valid <= 1'b0;
          while (pll_sb.pending() != 0) @(posedge clk);
        end
        send_sample(next_sample());
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pll_sb.errors == 0 && pll_sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
